// ===== src/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope gain unit.
package adsr_pkg;

  // Fixed field widths
  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 16;
  localparam int QUO_W          = 16;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_ADDR_W     = 3;
  localparam int FRAME_BITS_DEF = 24;
  localparam int FRAC_BITS      = 15;

  // Unity gain in Q1.15
  localparam logic [GAIN_W-1:0] UNITY = 16'd32768;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_SUSTAIN = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_NOTE    = 3'd4
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_ENV,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_OUT,
    ST_EMIT
  } state_t;

endpackage

// ===== src/adsr_envelope_gain_unit.sv =====
// ADSR envelope gain unit: frame counter, sequencer and shared multiplier.
//
// One input word per audio frame: a signed Q1.15 sample and a note_start flag
// that makes the frame frame zero of a new note. Each word returns one result
// word: the scaled sample, the Q1.15 gain used and a last flag on the final
// frame of the note (frame note+release-1). After that frame the counter holds
// and the gain is 0 until the next note_start.
// Channels are valid/ready. in_ready is high only while the sequencer is idle.
// A ramp frame (attack, decay or release) takes the envelope multiply, the
// restoring divider and the sample multiply; a sustain or finished frame takes
// only the sample multiply. One word is in flight at a time, so a new word is
// accepted only after the last one has been loaded into the output register.
// The result sits in an output register; a new input word may be accepted
// while it waits, and the block holds its next result until out_ready frees
// the register. Configuration writes (cfg_we) take effect at once and must
// only be made while the block is idle.
// Synchronous reset clears the counter to frame zero, all lengths to 0 and
// the sustain level to unity.
module adsr_envelope_gain_unit import adsr_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample_in,
  input  logic                        in_note_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_sample_out,
  output logic [GAIN_W-1:0]           out_gain,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata
);

  // Stored frame lengths are limited by both the register and FRAME_BITS
  localparam int FW  = (FRAME_BITS < CFG_DATA_W) ? FRAME_BITS : CFG_DATA_W;
  localparam int MBW = ((FW > GAIN_W) ? FW : GAIN_W) + 1;
  localparam int MAW = SAMPLE_W + 1;
  localparam int PW  = MAW + MBW;
  localparam int NW  = QUO_W + FW;

  // Configuration registers
  logic [FW-1:0]     attack_r, decay_r, release_r, note_r;
  logic [GAIN_W-1:0] sustain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      sustain_r <= UNITY;
      release_r <= '0;
      note_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ATTACK:  attack_r  <= cfg_wdata[FW-1:0];
        CFG_DECAY:   decay_r   <= cfg_wdata[FW-1:0];
        CFG_SUSTAIN: sustain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_RELEASE: release_r <= cfg_wdata[FW-1:0];
        CFG_NOTE:    note_r    <= cfg_wdata[FW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_t                    state_r, state_nxt;
  logic [FW:0]               cnt_r, cnt_nxt;
  logic [FW:0]               n_r, n_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [GAIN_W-1:0]         gain_r, gain_nxt;
  logic                      last_r, last_nxt;
  logic                      decay_ph_r, decay_ph_nxt;
  logic [GAIN_W-1:0]         op_a_r, op_a_nxt;
  logic [FW-1:0]             op_b_r, op_b_nxt;
  logic [FW-1:0]             den_r, den_nxt;
  logic signed [PW-1:0]      prod_r, prod_nxt;
  logic                      ov_r, ov_nxt;
  logic signed [SAMPLE_W-1:0] osmp_r, osmp_nxt;
  logic [GAIN_W-1:0]         ogain_r, ogain_nxt;
  logic                      olast_r, olast_nxt;

  // Phase compares on the current frame index
  logic [FW:0]       total;
  logic [FW:0]       att_dec;
  logic [FW:0]       n_minus_a;
  logic [FW:0]       n_minus_nt;
  logic [FW:0]       rel_left;
  logic [GAIN_W-1:0] sus_sat;

  assign total      = {1'b0, note_r} + {1'b0, release_r};
  assign att_dec    = {1'b0, attack_r} + {1'b0, decay_r};
  assign n_minus_a  = n_r - {1'b0, attack_r};
  assign n_minus_nt = n_r - {1'b0, note_r};
  assign rel_left   = {1'b0, release_r} - n_minus_nt;
  assign sus_sat    = (sustain_r > UNITY) ? UNITY : sustain_r;

  // Shared multiplier: envelope numerator, then sample scaling
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;

  always_comb begin
    if (state_r == ST_MUL_OUT) begin
      mul_a = {sample_r[SAMPLE_W-1], sample_r};
      mul_b = {{(MBW-GAIN_W){1'b0}}, gain_r};
    end else begin
      mul_a = {1'b0, op_a_r};
      mul_b = {{(MBW-FW){1'b0}}, op_b_r};
    end
  end

  assign mul_p = mul_a * mul_b;

  // Divider for the ramp quotient
  logic              div_start;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;

  adsr_div #(.FW(FW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r[NW-1:0]),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    sample_nxt   = sample_r;
    gain_nxt     = gain_r;
    last_nxt     = last_r;
    decay_ph_nxt = decay_ph_r;
    op_a_nxt     = op_a_r;
    op_b_nxt     = op_b_r;
    den_nxt      = den_r;
    prod_nxt     = prod_r;
    ov_nxt       = ov_r && !out_ready;
    osmp_nxt     = osmp_r;
    ogain_nxt    = ogain_r;
    olast_nxt    = olast_r;
    in_ready     = 1'b0;
    div_start    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sample_nxt = in_sample_in;
          n_nxt      = in_note_start ? '0 : cnt_r;
          state_nxt  = ST_EVAL;
        end
      end

      ST_EVAL: begin
        decay_ph_nxt = 1'b0;
        if (n_r < total) begin
          last_nxt = (n_r == total - 1'b1);
          cnt_nxt  = n_r + 1'b1;
          if (n_r < {1'b0, attack_r}) begin
            // attack ramp: n * unity / A
            op_a_nxt  = UNITY;
            op_b_nxt  = n_r[FW-1:0];
            den_nxt   = attack_r;
            state_nxt = ST_MUL_ENV;
          end else if (n_r < att_dec) begin
            // decay ramp: unity - (unity - S) * (n - A) / D
            op_a_nxt     = UNITY - sus_sat;
            op_b_nxt     = n_minus_a[FW-1:0];
            den_nxt      = decay_r;
            decay_ph_nxt = 1'b1;
            state_nxt    = ST_MUL_ENV;
          end else if (n_r >= {1'b0, note_r}) begin
            // release ramp: S * (R - (n - note)) / R
            op_a_nxt  = sus_sat;
            op_b_nxt  = rel_left[FW-1:0];
            den_nxt   = release_r;
            state_nxt = ST_MUL_ENV;
          end else begin
            gain_nxt  = sus_sat;
            state_nxt = ST_MUL_OUT;
          end
        end else begin
          // note finished: counter holds this frame index, gain is zero
          cnt_nxt   = n_r;
          gain_nxt  = '0;
          last_nxt  = 1'b0;
          state_nxt = ST_MUL_OUT;
        end
      end

      ST_MUL_ENV: begin
        prod_nxt  = mul_p;
        state_nxt = ST_DIV_START;
      end

      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          gain_nxt  = decay_ph_r ? (UNITY - div_quo) : div_quo;
          state_nxt = ST_MUL_OUT;
        end
      end

      ST_MUL_OUT: begin
        prod_nxt  = mul_p;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        // load the output register once it is free
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          osmp_nxt  = prod_r[SAMPLE_W+FRAC_BITS-1:FRAC_BITS];
          ogain_nxt = gain_r;
          olast_nxt = last_r;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    n_r        <= n_nxt;
    sample_r   <= sample_nxt;
    gain_r     <= gain_nxt;
    last_r     <= last_nxt;
    decay_ph_r <= decay_ph_nxt;
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    den_r      <= den_nxt;
    prod_r     <= prod_nxt;
    osmp_r     <= osmp_nxt;
    ogain_r    <= ogain_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_sample_out = osmp_r;
  assign out_gain       = ogain_r;
  assign out_last       = olast_r;

endmodule

// ===== src/adsr_div.sv =====
// Restoring divider, one quotient bit per cycle, for envelope ramps.
module adsr_div import adsr_pkg::*; #(
  parameter int FW = FRAME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [QUO_W+FW-1:0]  num,
  input  logic [FW-1:0]        den,
  output logic                 done,
  output logic [QUO_W-1:0]     quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FW-1:0]    rem_r, rem_nxt;
  logic [FW-1:0]    den_r, den_nxt;
  logic [QUO_W-1:0] qs_r, qs_nxt;
  logic [FW:0]      trial;
  logic [FW:0]      diff;

  // Trial subtract: shift next dividend bit into the remainder
  assign trial = {rem_r, qs_r[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    qs_nxt   = qs_r;
    if (start) begin
      // quotient fits QUO_W bits, so the high part is below the divisor
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W);
      rem_nxt  = num[QUO_W+FW-1:QUO_W];
      qs_nxt   = num[QUO_W-1:0];
      den_nxt  = den;
    end else if (busy_r) begin
      if (!diff[FW]) begin
        rem_nxt = diff[FW-1:0];
        qs_nxt  = {qs_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[FW-1:0];
        qs_nxt  = {qs_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    qs_r  <= qs_nxt;
  end

  assign done = done_r;
  assign quo  = qs_r;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the ADSR envelope gain unit.
`timescale 1ns / 1ps

module tb;
  import adsr_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          STALL_LEN   = 300;
  localparam int          TAIL_CYCLES = 40;
  localparam logic [23:0] LEN_MAX     = 24'hFFFFFF;
  localparam longint unsigned FULL_GAIN = UNITY;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start;
  } frame_word_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          gain;
    logic                       last;
  } frame_result_t;

  logic                       clk;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in  = '0;
  logic                       in_note_start = 1'b0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic [GAIN_W-1:0]          out_gain;
  logic                       out_last;
  logic                       cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0]      cfg_addr      = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata     = '0;

  // Envelope settings and frame counter as the block should hold them
  longint unsigned atk_len  = 0;
  longint unsigned dec_len  = 0;
  longint unsigned sus_lvl  = 32768;
  longint unsigned rel_len  = 0;
  longint unsigned note_len = 0;
  longint unsigned frame_n  = 0;

  frame_word_t   frame_queue[$];
  frame_result_t frame_exp[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_armed     = 1'b0;
  bit          stall_done     = 1'b0;
  int unsigned stall_cnt      = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned err_count      = 0;

  adsr_envelope_gain_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_note_start  (in_note_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_gain       (out_gain),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Envelope gain for frame n; phase tests in priority order
  function automatic longint unsigned env_gain(longint unsigned n, longint unsigned sus);
    if (n < atk_len) return (n * FULL_GAIN) / atk_len;
    if (n < atk_len + dec_len) return FULL_GAIN - ((FULL_GAIN - sus) * (n - atk_len)) / dec_len;
    if (n >= note_len) begin
      if (rel_len == 0) return 0;
      return (sus * (rel_len - (n - note_len))) / rel_len;
    end
    return sus;
  endfunction

  // Advance the frame counter by one word and work out its result
  function automatic frame_result_t predict_frame(logic signed [SAMPLE_W-1:0] smp,
                                                   logic start);
    longint unsigned total;
    longint unsigned sus;
    longint unsigned g;
    longint          prod;
    frame_result_t   res;
    total    = note_len + rel_len;
    sus      = (sus_lvl > FULL_GAIN) ? FULL_GAIN : sus_lvl;
    g        = 0;
    res.last = 1'b0;
    if (start) frame_n = 0;
    if (frame_n < total) begin
      g        = env_gain(frame_n, sus);
      res.last = (frame_n == total - 1);
      frame_n++;
    end
    prod       = longint'(smp) * longint'(g);
    res.sample = SAMPLE_W'(prod >>> FRAC_BITS);
    res.gain   = GAIN_W'(g);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_count++;
  endtask

  // One register write per cycle; cfg_we is left high for the next write
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ATTACK:  atk_len  = val;
      CFG_DECAY:   dec_len  = val;
      CFG_SUSTAIN: sus_lvl  = val[15:0];
      CFG_RELEASE: rel_len  = val;
      CFG_NOTE:    note_len = val;
      default: ;
    endcase
  endtask

  task automatic load_envelope(logic [23:0] atk, logic [23:0] dec, logic [23:0] sus,
                               logic [23:0] rel, logic [23:0] note);
    write_reg(CFG_ATTACK, atk);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_SUSTAIN, sus);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_NOTE, note);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(logic signed [SAMPLE_W-1:0] smp, logic start);
    frame_word_t w;
    w.sample = smp;
    w.start  = start;
    frame_queue.push_back(w);
  endtask

  // Block is idle once every queued word went in and every result came out
  task automatic wait_drained();
    @(posedge clk);
    while (frame_queue.size() != 0 || frame_exp.size() != 0 || in_valid) @(posedge clk);
  endtask

  // Mostly short lengths so notes finish; now and then zero or the maximum
  function automatic logic [23:0] pick_len(int unsigned len_cap);
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return LEN_MAX;
    if (r == 1) return '0;
    return 24'($urandom_range(len_cap));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      4: return 16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Random envelope, then whole notes with random samples and stray restarts
  task automatic run_random_phase(int unsigned n_items);
    logic [7:0]  junk;
    logic [15:0] sus16;
    int unsigned span;
    int unsigned k;
    int unsigned pushed;
    junk = 8'($urandom);
    case ($urandom_range(7))
      0: sus16 = 16'd0;
      1: sus16 = UNITY;
      2: sus16 = 16'hFFFF;
      3: sus16 = 16'($urandom_range(65535, 32769));
      default: sus16 = 16'($urandom_range(32768));
    endcase
    load_envelope(pick_len(6), pick_len(6), {junk, sus16}, pick_len(8), pick_len(12));
    span = 32'(note_len + rel_len + 3);
    if (span > 40) span = 40;
    pushed = 0;
    while (pushed < n_items) begin
      push_word(pick_sample(), 1'b1);
      pushed++;
      k = $urandom_range(span);
      repeat (k) begin
        push_word(pick_sample(), $urandom_range(15) == 0);
        pushed++;
      end
    end
  endtask

  // Input driver: predicts each word as it is accepted
  always @(posedge clk) begin : drive
    frame_word_t w;
    bit          holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        frame_exp.push_back(predict_frame(in_sample_in, in_note_start));
        holding = 1'b0;
      end
      if (!holding) begin
        if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = frame_queue.pop_front();
          in_valid      <= 1'b1;
          in_sample_in  <= w.sample;
          in_note_start <= w.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_exp.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: sample %0d gain %0d",
                                    out_sample_out, out_gain));
        end else begin
          want = frame_exp.pop_front();
          if (out_sample_out !== want.sample)
            report_mismatch($sformatf("sample_out got %0d want %0d",
                                      out_sample_out, want.sample));
          if (out_gain !== want.gain)
            report_mismatch($sformatf("gain got %0d want %0d", out_gain, want.gain));
          if (out_last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
        end
      end
      // long hold-off so the block backs up and drops in_ready
      if (hold_armed && !stall_done) begin
        out_ready <= 1'b0;
        if (stall_cnt == STALL_LEN) stall_done <= 1'b1;
        else stall_cnt <= stall_cnt + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned send_mode[4];
    int unsigned recv_mode[4];
    send_mode = '{0, 78, 0, 36};
    recv_mode = '{0, 0, 78, 36};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings give an empty note: gain stays 0
    push_word(-16'sd32768, 1'b0);
    push_word(16'sd32767, 1'b1);
    wait_drained();

    // Full envelope: attack, decay, sustain, release, last frame, finished
    load_envelope(24'd2, 24'd3, 24'd16384, 24'd4, 24'd6);
    push_word(-16'sd32768, 1'b1);
    push_word(16'sd32767, 1'b0);
    push_word(-16'sd32768, 1'b0);
    push_word(16'sd32767, 1'b0);
    push_word(-16'sd1, 1'b0);
    push_word(16'sd1, 1'b0);
    push_word(-16'sd32768, 1'b0);
    push_word(16'sd32767, 1'b0);
    push_word(-16'sd32768, 1'b0);
    push_word(-16'sd2, 1'b0);
    push_word(16'sd32767, 1'b0);
    push_word(16'sd12345, 1'b0);
    wait_drained();

    // Maximum lengths, sustain above unity, note shorter than attack plus decay
    load_envelope(LEN_MAX, LEN_MAX, 24'h00FFFF, LEN_MAX, 24'd1);
    push_word(16'sd32767, 1'b1);
    push_word(-16'sd32768, 1'b0);
    push_word(16'sd32767, 1'b0);
    wait_drained();

    // Zero attack, decay and note: release straight from frame zero
    load_envelope(24'd0, 24'd0, 24'd32768, 24'd3, 24'd0);
    push_word(-16'sd32768, 1'b1);
    push_word(16'sd32767, 1'b0);
    push_word(-16'sd32768, 1'b0);
    push_word(16'sd32767, 1'b0);
    wait_drained();

    // Random envelopes through each idling pattern
    for (int p = 0; p < 8; p++) begin
      send_idle_pct  = send_mode[p % 4];
      recv_stall_pct = recv_mode[p % 4];
      run_random_phase(40);
      wait_drained();
    end

    // Receiver holds off while the sender keeps offering words
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b1;
    run_random_phase(24);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_exp.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frame_exp.size()));
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/adsr_pkg.sv
src/adsr_div.sv
src/adsr_envelope_gain_unit.sv
dv/tb.sv
